FILE: rtl/fpem_pkg.sv
// Package for the filtered power and energy meter: widths, register indexes,
// configuration and queue item types, and the saturation helper.
// No dependencies; every other file of the block imports this package.
package fpem_pkg;

  // Field widths
  localparam int ADC_BITS   = 12;
  localparam int DIFF_W     = ADC_BITS + 1;
  localparam int GAIN_W     = 24;
  localparam int WEIGHT_W   = 16;
  localparam int PERIOD_W   = 24;
  localparam int VAL_W      = 32;
  localparam int ENERGY_W   = 64;

  // Queue between the front and the back engine
  localparam int QUEUE_DEPTH_DEF = 2;

  // APB register port
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = 3;

  localparam logic [REG_IDX_W-1:0] REG_VOLT_OFS  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_CURR_OFS  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_VOLT_GAIN = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_CURR_GAIN = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_OLD_WT    = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_NEW_WT    = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_PERIOD    = 3'd6;

  localparam logic [WEIGHT_W-1:0] NEW_WEIGHT_RESET = 16'hFFFF;

  // Saturation limits of a Q16.16 value, held at 64 bits
  localparam logic signed [63:0] VAL_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] VAL_MIN = 64'shFFFF_FFFF_8000_0000;

  localparam logic signed [ENERGY_W-1:0] ENERGY_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [ENERGY_W-1:0] ENERGY_MIN = 64'sh8000_0000_0000_0000;

  // Software-written calibration
  typedef struct packed {
    logic [ADC_BITS-1:0] voltage_zero_offset;
    logic [ADC_BITS-1:0] current_zero_offset;
    logic [GAIN_W-1:0]   volts_per_count;
    logic [GAIN_W-1:0]   amps_per_count;
    logic [WEIGHT_W-1:0] old_weight;
    logic [WEIGHT_W-1:0] new_weight;
    logic [PERIOD_W-1:0] sample_period;
  } fpem_cfg_t;

  // Offset-corrected sample pair handed from the front to the back engine
  typedef struct packed {
    logic signed [DIFF_W-1:0] vdiff;
    logic signed [DIFF_W-1:0] cdiff;
  } fpem_item_t;

  // Clamp a signed value to the Q16.16 range.
  function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [63:0] x);
    logic signed [VAL_W-1:0] r;
    if (x > VAL_MAX) begin
      r = VAL_MAX[VAL_W-1:0];
    end else if (x < VAL_MIN) begin
      r = VAL_MIN[VAL_W-1:0];
    end else begin
      r = x[VAL_W-1:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/fpem_if.sv
// Valid/ready channel interfaces for the sample input and the result output.
// Depends on fpem_pkg for the field widths.
interface fpem_in_if import fpem_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ADC_BITS-1:0] voltage_sample;
  logic [ADC_BITS-1:0] current_sample;

  modport source (output valid, voltage_sample, current_sample, input ready);
  modport sink (input valid, voltage_sample, current_sample, output ready);
endinterface

interface fpem_out_if import fpem_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [VAL_W-1:0]    filtered_voltage;
  logic signed [VAL_W-1:0]    filtered_current;
  logic signed [VAL_W-1:0]    power_value;
  logic signed [ENERGY_W-1:0] energy_total;

  modport source (output valid, filtered_voltage, filtered_current, power_value,
                  energy_total, input ready);
  modport sink (input valid, filtered_voltage, filtered_current, power_value,
                energy_total, output ready);
endinterface

FILE: rtl/fpem_regs.sv
// APB register file holding the offsets, gains, filter weights and sample period.
// Depends on fpem_pkg for the register indexes and the configuration struct.
module fpem_regs import fpem_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output fpem_cfg_t             cfg
);

  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  // Register writes; an index past the list is dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.voltage_zero_offset <= '0;
      cfg.current_zero_offset <= '0;
      cfg.volts_per_count     <= '0;
      cfg.amps_per_count      <= '0;
      cfg.old_weight          <= '0;
      cfg.new_weight          <= NEW_WEIGHT_RESET;
      cfg.sample_period       <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_VOLT_OFS:  cfg.voltage_zero_offset <= pwdata[ADC_BITS-1:0];
        REG_CURR_OFS:  cfg.current_zero_offset <= pwdata[ADC_BITS-1:0];
        REG_VOLT_GAIN: cfg.volts_per_count     <= pwdata[GAIN_W-1:0];
        REG_CURR_GAIN: cfg.amps_per_count      <= pwdata[GAIN_W-1:0];
        REG_OLD_WT:    cfg.old_weight          <= pwdata[WEIGHT_W-1:0];
        REG_NEW_WT:    cfg.new_weight          <= pwdata[WEIGHT_W-1:0];
        REG_PERIOD:    cfg.sample_period       <= pwdata[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  // Read-back mux.
  always_comb begin
    unique case (reg_idx)
      REG_VOLT_OFS:  prdata = APB_DATA_W'(cfg.voltage_zero_offset);
      REG_CURR_OFS:  prdata = APB_DATA_W'(cfg.current_zero_offset);
      REG_VOLT_GAIN: prdata = APB_DATA_W'(cfg.volts_per_count);
      REG_CURR_GAIN: prdata = APB_DATA_W'(cfg.amps_per_count);
      REG_OLD_WT:    prdata = APB_DATA_W'(cfg.old_weight);
      REG_NEW_WT:    prdata = APB_DATA_W'(cfg.new_weight);
      REG_PERIOD:    prdata = APB_DATA_W'(cfg.sample_period);
      default:       prdata = '0;
    endcase
  end

endmodule

FILE: rtl/fpem_front.sv
// Front end: takes sample transfers and removes the zero offsets as signed values.
// Depends on fpem_pkg and the fpem_in_if interface.
module fpem_front import fpem_pkg::*; (
  input  fpem_cfg_t   cfg,
  fpem_in_if.sink     samples,
  output logic        push_valid,
  input  logic        push_ready,
  output fpem_item_t  push_item
);

  // A transfer is taken whenever the queue has room.
  assign samples.ready = push_ready;
  assign push_valid    = samples.valid;

  // Offset-corrected counts; a sample below its offset goes negative.
  assign push_item.vdiff = $signed({1'b0, samples.voltage_sample})
                         - $signed({1'b0, cfg.voltage_zero_offset});
  assign push_item.cdiff = $signed({1'b0, samples.current_sample})
                         - $signed({1'b0, cfg.current_zero_offset});

endmodule

FILE: rtl/fpem_queue.sv
// Small FIFO that decouples the front end from the back engine.
// Depends on fpem_pkg for the item type.
module fpem_queue import fpem_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push_valid,
  output logic       push_ready,
  input  fpem_item_t push_item,
  output logic       pop_valid,
  input  logic       pop_ready,
  output fpem_item_t pop_item
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  fpem_item_t       entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push_fire;
  logic             pop_fire;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = entries[rd_ptr];
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push_fire) begin
      entries[wr_ptr] <= push_item;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_fire) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop_fire) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push_fire && !pop_fire) begin
        count <= count + 1'b1;
      end else if (pop_fire && !push_fire) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/fpem_back.sv
// Back engine: scaling, IIR filters, power and saturating energy over five steps,
// with the output register. Depends on fpem_pkg and the fpem_out_if interface.
module fpem_back import fpem_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  fpem_cfg_t   cfg,
  input  logic        pop_valid,
  output logic        pop_ready,
  input  fpem_item_t  pop_item,
  fpem_out_if.source  results
);

  localparam int SCL_W    = DIFF_W + GAIN_W + 1;
  localparam int SCALED_W = SCL_W - 4;
  localparam int OLD_W    = WEIGHT_W + 1 + VAL_W;
  localparam int NEW_W    = WEIGHT_W + 1 + SCALED_W;
  localparam int ACC_W    = NEW_W + 1;
  localparam int PWR_W    = 2 * VAL_W;
  localparam int EPROD_W  = VAL_W + PERIOD_W + 1;
  localparam int DE_W     = EPROD_W - 8;
  localparam int SUM_W    = ENERGY_W + 1;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCALE  = 3'd1;
  localparam logic [2:0] ST_FILT   = 3'd2;
  localparam logic [2:0] ST_POWER  = 3'd3;
  localparam logic [2:0] ST_ENERGY = 3'd4;
  localparam logic [2:0] ST_ACCUM  = 3'd5;

  logic [2:0]                 state;
  logic                       pop_fire;
  logic signed [DIFF_W-1:0]   vdiff;
  logic signed [DIFF_W-1:0]   cdiff;
  logic signed [SCL_W-1:0]    v_scl_prod;
  logic signed [SCL_W-1:0]    c_scl_prod;
  logic signed [OLD_W-1:0]    v_old_prod;
  logic signed [OLD_W-1:0]    c_old_prod;
  logic signed [VAL_W-1:0]    last_voltage;
  logic signed [VAL_W-1:0]    last_current;
  logic signed [PWR_W-1:0]    pw_prod;
  logic signed [VAL_W-1:0]    power_q;
  logic signed [EPROD_W-1:0]  e_prod;
  logic signed [ENERGY_W-1:0] energy_sum;
  logic                       out_valid;
  logic signed [VAL_W-1:0]    out_voltage;
  logic signed [VAL_W-1:0]    out_current;
  logic signed [VAL_W-1:0]    out_power;
  logic signed [ENERGY_W-1:0] out_energy;

  logic signed [SCALED_W-1:0] v_scaled;
  logic signed [SCALED_W-1:0] c_scaled;
  logic signed [NEW_W-1:0]    v_new_prod;
  logic signed [NEW_W-1:0]    c_new_prod;
  logic signed [ACC_W-1:0]    v_acc;
  logic signed [ACC_W-1:0]    c_acc;
  logic signed [VAL_W-1:0]    v_filt;
  logic signed [VAL_W-1:0]    c_filt;
  logic signed [VAL_W-1:0]    p_sat;
  logic signed [DE_W-1:0]     de;
  logic signed [SUM_W-1:0]    sum_ext;
  logic signed [ENERGY_W-1:0] energy_next;

  // A new item is taken when idle, or straight out of the last step once the
  // result has a free output register.
  assign pop_ready = (state == ST_IDLE) || ((state == ST_ACCUM) && !out_valid);
  assign pop_fire  = pop_valid && pop_ready;

  // Filter step: drop 4 fraction bits of the scaled sample, weight it and add
  // the weighted previous value, then drop 16 more bits and saturate.
  assign v_scaled   = $signed(v_scl_prod[SCL_W-1:4]);
  assign c_scaled   = $signed(c_scl_prod[SCL_W-1:4]);
  assign v_new_prod = $signed({1'b0, cfg.new_weight}) * v_scaled;
  assign c_new_prod = $signed({1'b0, cfg.new_weight}) * c_scaled;
  assign v_acc      = ACC_W'(v_old_prod) + ACC_W'(v_new_prod);
  assign c_acc      = ACC_W'(c_old_prod) + ACC_W'(c_new_prod);
  assign v_filt     = sat_val(64'($signed(v_acc[ACC_W-1:16])));
  assign c_filt     = sat_val(64'($signed(c_acc[ACC_W-1:16])));

  // Power in Q16.16 from the Q32.32 product.
  assign p_sat = sat_val(64'($signed(pw_prod[PWR_W-1:16])));

  // Energy increment in Q32.32 and the saturating accumulate.
  assign de      = $signed(e_prod[EPROD_W-1:8]);
  assign sum_ext = SUM_W'(energy_sum) + SUM_W'(de);
  always_comb begin
    if (sum_ext[SUM_W-1] != sum_ext[SUM_W-2]) begin
      energy_next = sum_ext[SUM_W-1] ? ENERGY_MIN : ENERGY_MAX;
    end else begin
      energy_next = sum_ext[ENERGY_W-1:0];
    end
  end

  // Step sequencer and the filter and energy state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      last_voltage <= '0;
      last_current <= '0;
      energy_sum   <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (results.valid && results.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (pop_fire) begin
            state <= ST_SCALE;
          end
        end
        ST_SCALE: begin
          state <= ST_FILT;
        end
        ST_FILT: begin
          last_voltage <= v_filt;
          last_current <= c_filt;
          state        <= ST_POWER;
        end
        ST_POWER: begin
          state <= ST_ENERGY;
        end
        ST_ENERGY: begin
          state <= ST_ACCUM;
        end
        ST_ACCUM: begin
          if (!out_valid) begin
            energy_sum <= energy_next;
            out_valid  <= 1'b1;
            state      <= pop_fire ? ST_SCALE : ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Datapath registers; the scale step holds two multipliers per channel, the power and energy steps one each.
  always_ff @(posedge clk) begin
    if (pop_fire) begin
      vdiff <= pop_item.vdiff;
      cdiff <= pop_item.cdiff;
    end
    if (state == ST_SCALE) begin
      v_scl_prod <= vdiff * $signed({1'b0, cfg.volts_per_count});
      c_scl_prod <= cdiff * $signed({1'b0, cfg.amps_per_count});
      v_old_prod <= $signed({1'b0, cfg.old_weight}) * last_voltage;
      c_old_prod <= $signed({1'b0, cfg.old_weight}) * last_current;
    end
    if (state == ST_POWER) begin
      pw_prod <= last_voltage * last_current;
    end
    if (state == ST_ENERGY) begin
      power_q <= p_sat;
      e_prod  <= p_sat * $signed({1'b0, cfg.sample_period});
    end
    if ((state == ST_ACCUM) && !out_valid) begin
      out_voltage <= last_voltage;
      out_current <= last_current;
      out_power   <= power_q;
      out_energy  <= energy_next;
    end
  end

  assign results.valid            = out_valid;
  assign results.filtered_voltage = out_voltage;
  assign results.filtered_current = out_current;
  assign results.power_value      = out_power;
  assign results.energy_total     = out_energy;

endmodule

FILE: rtl/filtered_power_energy_meter_core.sv
// Top level of the filtered power and energy meter.
// Depends on fpem_pkg, fpem_if, fpem_regs, fpem_front, fpem_queue and fpem_back.
//
// Usage:
//   samples carries one voltage and one current ADC count per transfer.
//   results carries filtered voltage, filtered current, power (all Q16.16)
//   and the running energy total (Q32.32), one result per sample transfer.
//   The APB port holds offsets, gains, filter weights and the sample period;
//   write it only while no sample is in flight.
// Flow:
//   A sample is taken into a Q_DEPTH-entry queue whenever the queue has room;
//   from there it passes through the back engine's steps to the output register.
//   The back engine works on one item at a time in five steps (scale, filter,
//   power, energy, accumulate) and takes the next item at the accumulate step.
// Reset and stall:
//   Reset clears the filter history, the energy total and the queue, and loads
//   the register defaults. While results is stalled, the held result waits in
//   the output register, the engine finishes its current item and stops, and
//   the queue keeps taking samples until it is full.
module filtered_power_energy_meter_core import fpem_pkg::*; #(
  parameter int Q_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  fpem_in_if.sink               samples,
  fpem_out_if.source            results,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  fpem_cfg_t  cfg;
  logic       push_valid;
  logic       push_ready;
  fpem_item_t push_item;
  logic       pop_valid;
  logic       pop_ready;
  fpem_item_t pop_item;

  // Configuration registers.
  fpem_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Offset removal on the way in.
  fpem_front u_front (
    .cfg        (cfg),
    .samples    (samples),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  // Decoupling queue.
  fpem_queue #(
    .DEPTH (Q_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  // Arithmetic engine and output register.
  fpem_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item),
    .results   (results)
  );

endmodule

FILE: rtl/fpem_checker.sv
// Port-level checks on the meter: output hold, result spacing and item count.
// Depends on fpem_pkg; bound to filtered_power_energy_meter_core below.
module fpem_checker import fpem_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic signed [VAL_W-1:0]    filtered_voltage,
  input logic signed [VAL_W-1:0]    filtered_current,
  input logic signed [VAL_W-1:0]    power_value,
  input logic signed [ENERGY_W-1:0] energy_total
);

  // Items held at once: the queue, the engine and the output register.
  localparam int LIMIT = DEPTH + 2;
  localparam int CNT_W = $clog2(LIMIT + 2);

  logic [CNT_W-1:0] outstanding;
  logic             in_fire;
  logic             out_fire;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  // Samples taken whose results have not been delivered.
  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else if (in_fire && !out_fire) begin
      outstanding <= outstanding + 1'b1;
    end else if (out_fire && !in_fire) begin
      outstanding <= outstanding - 1'b1;
    end
  end

  // A stalled result keeps its value.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(filtered_voltage)
      && $stable(filtered_current) && $stable(power_value) && $stable(energy_total))
  else $error("stalled result changed");

  // The engine works through its steps for each item, so results never come back to back.
  assert property (@(posedge clk) disable iff (rst) out_fire |=> !out_valid)
  else $error("result delivered in consecutive cycles");

  // Every result belongs to a sample that was taken.
  assert property (@(posedge clk) disable iff (rst) out_fire |-> outstanding != '0)
  else $error("result without a pending sample");

  // Intake stops once the queue, the engine and the output register are full.
  assert property (@(posedge clk) disable iff (rst) outstanding <= CNT_W'(LIMIT))
  else $error("more samples in flight than the block can hold");

endmodule

bind filtered_power_energy_meter_core fpem_checker #(
  .DEPTH (Q_DEPTH)
) u_fpem_checker (
  .clk              (clk),
  .rst              (rst),
  .in_valid         (samples.valid),
  .in_ready         (samples.ready),
  .out_valid        (results.valid),
  .out_ready        (results.ready),
  .filtered_voltage (results.filtered_voltage),
  .filtered_current (results.filtered_current),
  .power_value      (results.power_value),
  .energy_total     (results.energy_total)
);

FILE: dv/filtered_power_energy_meter_core_tb.sv
`timescale 1ns / 100ps
// Testbench for filtered_power_energy_meter_core: sample pairs in, one checked result per pair.
// Depends on fpem_pkg, the fpem_in_if/fpem_out_if interfaces and the core RTL.
module filtered_power_energy_meter_core_tb;
  import fpem_pkg::*;

  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 7;
  localparam int SETTLE_CYCLES = 12;
  localparam int LONG_HOLD     = 300;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_ITEMS   = 300;
  localparam int MAX_REPORTS   = 10;

  localparam logic [REG_IDX_W-1:0] REG_UNMAPPED = 3'd7;
  localparam logic [ADC_BITS-1:0]  ADC_MAX      = '1;
  localparam logic [ADC_BITS-1:0]  ADC_MID      = 12'd2048;
  localparam logic [GAIN_W-1:0]    GAIN_MAX     = '1;
  localparam logic [WEIGHT_W-1:0]  WEIGHT_MAX   = '1;
  localparam logic [WEIGHT_W-1:0]  WEIGHT_QTR   = 16'h4000;
  localparam logic [PERIOD_W-1:0]  PERIOD_MAX   = '1;

  // One expected meter reading
  typedef struct packed {
    logic signed [VAL_W-1:0]    voltage;
    logic signed [VAL_W-1:0]    current;
    logic signed [VAL_W-1:0]    power;
    logic signed [ENERGY_W-1:0] energy;
  } meter_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  fpem_in_if  samples_if ();
  fpem_out_if results_if ();

  filtered_power_energy_meter_core u_top (
    .clk     (clk),
    .rst     (rst),
    .samples (samples_if),
    .results (results_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Calibration shadow and filter/energy history of the predictor.
  fpem_cfg_t                  cal;
  logic signed [VAL_W-1:0]    prev_volts;
  logic signed [VAL_W-1:0]    prev_amps;
  logic signed [ENERGY_W-1:0] energy_acc;

  meter_result_t expected_readings[$];

  int mismatch_count = 0;
  int readings_checked = 0;
  int pairs_sent = 0;
  int settings_loaded = 0;
  int cycle_count = 0;

  // Sender burst shaping and receiver stall pattern.
  int gap_max = 0;
  int burst_left = 0;
  int stall_pct = 0;
  int hold_requests = 0;
  int holds_served;
  int hold_left;
  int run_left;

  always #CLK_HALF clk = ~clk;

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d readings outstanding.", cycle_count,
               expected_readings.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Saturate a 64-bit value to signed Q16.16.
  function automatic logic signed [VAL_W-1:0] clamp_q16(input logic signed [63:0] x);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sd2147483647;
    lo = -64'sd2147483648;
    if (x > hi) return hi[VAL_W-1:0];
    if (x < lo) return lo[VAL_W-1:0];
    return x[VAL_W-1:0];
  endfunction

  // Offset, gain and first-order IIR of one channel.
  function automatic logic signed [VAL_W-1:0] filter_channel(
      input logic [ADC_BITS-1:0] count, input logic [ADC_BITS-1:0] offset,
      input logic [GAIN_W-1:0] gain, input logic signed [VAL_W-1:0] prev);
    logic signed [63:0] diff;
    logic signed [63:0] scaled;
    logic signed [63:0] prev64;
    logic signed [63:0] acc;
    diff   = $signed({52'd0, count}) - $signed({52'd0, offset});
    scaled = (diff * $signed({40'd0, gain})) >>> 4;
    prev64 = prev;
    acc    = $signed({48'd0, cal.old_weight}) * prev64
           + $signed({48'd0, cal.new_weight}) * scaled;
    return clamp_q16(acc >>> 16);
  endfunction

  // Advance the meter by one sample pair and return the reading it produces.
  function automatic meter_result_t predict_reading(input logic [ADC_BITS-1:0] vcount,
                                                    input logic [ADC_BITS-1:0] ccount);
    meter_result_t r;
    logic signed [63:0] v64;
    logic signed [63:0] c64;
    logic signed [63:0] p64;
    logic signed [63:0] delta;
    logic signed [63:0] sum;
    r.voltage = filter_channel(vcount, cal.voltage_zero_offset, cal.volts_per_count,
                               prev_volts);
    r.current = filter_channel(ccount, cal.current_zero_offset, cal.amps_per_count,
                               prev_amps);
    v64 = r.voltage;
    c64 = r.current;
    r.power = clamp_q16((v64 * c64) >>> 16);
    p64 = r.power;
    delta = (p64 * $signed({40'd0, cal.sample_period})) >>> 8;
    sum = energy_acc + delta;
    // Saturate when both operands share a sign that the sum lost.
    if (!energy_acc[63] && !delta[63] && sum[63]) begin
      sum = ENERGY_MAX;
    end else if (energy_acc[63] && delta[63] && !sum[63]) begin
      sum = ENERGY_MIN;
    end
    r.energy   = sum;
    energy_acc = sum;
    prev_volts = r.voltage;
    prev_amps  = r.current;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("%0d ns: %s mismatch: expected %h, got %h", $time, what, want, got);
    end
  endtask

  // Compare each output transfer with the oldest predicted reading.
  always @(posedge clk) begin
    meter_result_t want;
    if (!rst && results_if.valid && results_if.ready) begin
      if (expected_readings.size() == 0) begin
        report_mismatch("unexpected reading", '0, results_if.energy_total);
      end else begin
        want = expected_readings.pop_front();
        readings_checked++;
        if (results_if.filtered_voltage !== want.voltage)
          report_mismatch("filtered_voltage", want.voltage, results_if.filtered_voltage);
        if (results_if.filtered_current !== want.current)
          report_mismatch("filtered_current", want.current, results_if.filtered_current);
        if (results_if.power_value !== want.power)
          report_mismatch("power_value", want.power, results_if.power_value);
        if (results_if.energy_total !== want.energy)
          report_mismatch("energy_total", want.energy, results_if.energy_total);
      end
    end
  end

  // Receiver: random ready runs, plus a long hold whenever one is requested.
  always @(posedge clk) begin
    if (rst) begin
      results_if.ready <= 1'b0;
      holds_served     <= 0;
      hold_left        <= 0;
      run_left         <= 0;
    end else if (holds_served != hold_requests) begin
      holds_served     <= holds_served + 1;
      hold_left        <= LONG_HOLD;
      results_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left        <= hold_left - 1;
      results_if.ready <= 1'b0;
    end else if (run_left == 0) begin
      run_left         <= $urandom_range(1, 8);
      results_if.ready <= ($urandom_range(0, 99) >= stall_pct);
    end else begin
      run_left <= run_left - 1;
    end
  end

  // Offer one sample pair, in bursts separated by random gaps.
  task automatic send_pair(input logic [ADC_BITS-1:0] vcount,
                           input logic [ADC_BITS-1:0] ccount);
    int gap;
    if (burst_left == 0) begin
      gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
      if (gap > 0) begin
        samples_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    samples_if.valid          <= 1'b1;
    samples_if.voltage_sample <= vcount;
    samples_if.current_sample <= ccount;
    @(posedge clk);
    while (!samples_if.ready) @(posedge clk);
    expected_readings.push_back(predict_reading(vcount, ccount));
    burst_left--;
    pairs_sent++;
  endtask

  // Stop offering and wait until every predicted reading has come back.
  task automatic wait_drained();
    samples_if.valid <= 1'b0;
    burst_left = 0;
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One APB setup and access pair.
  task automatic apb_transfer(input logic wr, input logic [REG_IDX_W-1:0] idx,
                              input logic [APB_DATA_W-1:0] wdata,
                              output logic [APB_DATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic logic [APB_DATA_W-1:0] reg_field_mask(input logic [REG_IDX_W-1:0] idx);
    case (idx) inside
      REG_VOLT_OFS, REG_CURR_OFS:                return 32'h0000_0FFF;
      REG_VOLT_GAIN, REG_CURR_GAIN, REG_PERIOD:  return 32'h00FF_FFFF;
      REG_OLD_WT, REG_NEW_WT:                    return 32'h0000_FFFF;
      default:                                   return '0;
    endcase
  endfunction

  function automatic logic [APB_DATA_W-1:0] reg_shadow(input logic [REG_IDX_W-1:0] idx);
    case (idx)
      REG_VOLT_OFS:  return 32'(cal.voltage_zero_offset);
      REG_CURR_OFS:  return 32'(cal.current_zero_offset);
      REG_VOLT_GAIN: return 32'(cal.volts_per_count);
      REG_CURR_GAIN: return 32'(cal.amps_per_count);
      REG_OLD_WT:    return 32'(cal.old_weight);
      REG_NEW_WT:    return 32'(cal.new_weight);
      REG_PERIOD:    return 32'(cal.sample_period);
      default:       return '0;
    endcase
  endfunction

  // Write one register; bits above the field carry noise that must be dropped.
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [APB_DATA_W-1:0] value);
    logic [APB_DATA_W-1:0] data;
    logic [APB_DATA_W-1:0] unused;
    data = (value & reg_field_mask(idx)) | ($urandom() & ~reg_field_mask(idx));
    apb_transfer(1'b1, idx, data, unused);
    case (idx)
      REG_VOLT_OFS:  cal.voltage_zero_offset = data[ADC_BITS-1:0];
      REG_CURR_OFS:  cal.current_zero_offset = data[ADC_BITS-1:0];
      REG_VOLT_GAIN: cal.volts_per_count     = data[GAIN_W-1:0];
      REG_CURR_GAIN: cal.amps_per_count      = data[GAIN_W-1:0];
      REG_OLD_WT:    cal.old_weight          = data[WEIGHT_W-1:0];
      REG_NEW_WT:    cal.new_weight          = data[WEIGHT_W-1:0];
      REG_PERIOD:    cal.sample_period       = data[PERIOD_W-1:0];
      default:       ;
    endcase
  endtask

  // Read every mapped register back and compare with the shadow.
  task automatic check_registers();
    logic [APB_DATA_W-1:0] got;
    for (int i = REG_VOLT_OFS; i <= REG_PERIOD; i++) begin
      apb_transfer(1'b0, REG_IDX_W'(i), '0, got);
      if (got !== reg_shadow(REG_IDX_W'(i)))
        report_mismatch($sformatf("register %0d readback", i), reg_shadow(REG_IDX_W'(i)), got);
    end
  endtask

  task automatic load_calibration(input fpem_cfg_t c);
    wait_drained();
    write_reg(REG_VOLT_OFS,  32'(c.voltage_zero_offset));
    write_reg(REG_CURR_OFS,  32'(c.current_zero_offset));
    write_reg(REG_VOLT_GAIN, 32'(c.volts_per_count));
    write_reg(REG_CURR_GAIN, 32'(c.amps_per_count));
    write_reg(REG_OLD_WT,    32'(c.old_weight));
    write_reg(REG_NEW_WT,    32'(c.new_weight));
    write_reg(REG_PERIOD,    32'(c.sample_period));
    check_registers();
    settings_loaded++;
  endtask

  function automatic fpem_cfg_t make_cal(
      input logic [ADC_BITS-1:0] vofs, input logic [ADC_BITS-1:0] cofs,
      input logic [GAIN_W-1:0] vgain, input logic [GAIN_W-1:0] cgain,
      input logic [WEIGHT_W-1:0] oldw, input logic [WEIGHT_W-1:0] neww,
      input logic [PERIOD_W-1:0] period);
    fpem_cfg_t c;
    c.voltage_zero_offset = vofs;
    c.current_zero_offset = cofs;
    c.volts_per_count     = vgain;
    c.amps_per_count      = cgain;
    c.old_weight          = oldw;
    c.new_weight          = neww;
    c.sample_period       = period;
    return c;
  endfunction

  // Field value biased toward zero, all ones and small magnitudes.
  function automatic logic [31:0] pick_value(input int width);
    logic [31:0] top;
    top = (32'd1 << width) - 1;
    case ($urandom_range(0, 7)) inside
      0:       return '0;
      1:       return top;
      2, 3:    return $urandom_range(0, 4095) & top;
      default: return $urandom() & top;
    endcase
  endfunction

  function automatic logic [ADC_BITS-1:0] pick_count();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return ADC_MAX;
      default: return ADC_BITS'($urandom_range(0, 4095));
    endcase
  endfunction

  // Default calibration: zero gains give all-zero readings.
  task automatic test_reset_defaults();
    check_registers();
    send_pair('0, '0);
    send_pair(ADC_MAX, ADC_MAX);
    send_pair(12'hAAA, 12'h555);
  endtask

  // Full-scale gains drive both filters and the product into saturation.
  task automatic test_saturation_extremes();
    gap_max   = 3;
    stall_pct = 30;
    load_calibration(make_cal('0, '0, GAIN_MAX, GAIN_MAX, '0, WEIGHT_MAX, PERIOD_MAX));
    send_pair(ADC_MAX, ADC_MAX);
    send_pair('0, '0);
    send_pair(ADC_MAX, 12'd1);
    // Samples below the offset give negative differences.
    load_calibration(make_cal(ADC_MAX, ADC_MAX, GAIN_MAX, GAIN_MAX, '0, WEIGHT_MAX,
                              PERIOD_MAX));
    send_pair('0, '0);
    send_pair('0, ADC_MAX);
    send_pair(ADC_MAX, '0);
    // Opposite signs push power and the energy total negative.
    load_calibration(make_cal(ADC_MAX, '0, GAIN_MAX, GAIN_MAX, '0, WEIGHT_MAX, PERIOD_MAX));
    send_pair('0, ADC_MAX);
    send_pair(12'd100, 12'd3000);
  endtask

  // Differences of plus and minus one with unit gain check floor rounding of each shift.
  task automatic test_floor_rounding();
    load_calibration(make_cal(ADC_MID, ADC_MID, 24'd1, 24'd1, WEIGHT_QTR, WEIGHT_QTR,
                              24'd1));
    send_pair(ADC_MID - 12'd1, ADC_MID + 12'd1);
    send_pair(ADC_MID - 12'd1, ADC_MID - 12'd1);
    send_pair(ADC_MID + 12'd1, ADC_MID + 12'd1);
  endtask

  // Weight extremes: pure new sample, pure history, zero weights, and a write off the map.
  task automatic test_filter_weights();
    load_calibration(make_cal(12'd1000, 12'd3000, 24'h10_0000, 24'h08_0000, '0, WEIGHT_MAX,
                              24'h01_0000));
    send_pair(12'd3500, 12'd200);
    wait_drained();
    write_reg(REG_OLD_WT, 32'(WEIGHT_MAX));
    write_reg(REG_NEW_WT, '0);
    send_pair(12'd10, 12'd4000);
    send_pair(ADC_MAX, '0);
    wait_drained();
    write_reg(REG_OLD_WT, '0);
    send_pair(12'd2000, 12'd2000);
    wait_drained();
    write_reg(REG_UNMAPPED, '1);
    check_registers();
    send_pair(ADC_MAX, ADC_MAX);
  endtask

  // Random calibrations with varied sender gaps and receiver stalls.
  task automatic test_random_calibrations();
    fpem_cfg_t c;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      c.voltage_zero_offset = ADC_BITS'(pick_value(ADC_BITS));
      c.current_zero_offset = ADC_BITS'(pick_value(ADC_BITS));
      c.volts_per_count     = GAIN_W'(pick_value(GAIN_W));
      c.amps_per_count      = GAIN_W'(pick_value(GAIN_W));
      c.old_weight          = WEIGHT_W'(pick_value(WEIGHT_W));
      c.new_weight          = WEIGHT_W'(pick_value(WEIGHT_W));
      c.sample_period       = PERIOD_W'(pick_value(PERIOD_W));
      if (ph == 1) begin
        c = make_cal(ADC_MAX, ADC_MAX, GAIN_MAX, GAIN_MAX, WEIGHT_MAX, WEIGHT_MAX,
                     PERIOD_MAX);
      end
      // The first phase runs with no idling on either side.
      gap_max   = (ph == 0) ? 0 : $urandom_range(0, 6);
      stall_pct = (ph == 0) ? 0 : $urandom_range(0, 70);
      load_calibration(c);
      repeat (PHASE_ITEMS) send_pair(pick_count(), pick_count());
    end
  endtask

  // Long output hold while pairs keep coming, so the queue fills and input stalls.
  task automatic test_output_stall();
    load_calibration(make_cal(12'd2040, 12'd2050, 24'h02_0000, 24'h00_8000, 16'h8000,
                              16'h8000, 24'h00_4000));
    gap_max   = 0;
    stall_pct = 0;
    hold_requests++;
    repeat (40) send_pair(pick_count(), pick_count());
  endtask

  initial begin
    psel                      <= 1'b0;
    penable                   <= 1'b0;
    pwrite                    <= 1'b0;
    paddr                     <= '0;
    pwdata                    <= '0;
    samples_if.valid          <= 1'b0;
    samples_if.voltage_sample <= '0;
    samples_if.current_sample <= '0;
    cal                        = '0;
    cal.new_weight             = NEW_WEIGHT_RESET;
    prev_volts                 = '0;
    prev_amps                  = '0;
    energy_acc                 = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_saturation_extremes();
    test_floor_rounding();
    test_filter_weights();
    test_random_calibrations();
    test_output_stall();
    wait_drained();

    $display("Sent %0d sample pairs under %0d calibrations; %0d readings checked, %0d mismatches.",
             pairs_sent, settings_loaded, readings_checked, mismatch_count);
    $display("Covered saturation, negative offsets, floor rounding, weight extremes, long stall.");
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
